@@ hw/rtl/qvd_pkg.sv @@
// quantized vector distance: shared constants, mode codes and control structs
// no dependencies; imported by every module of the block
`default_nettype none

package qvd_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned SUM_WIDTH = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned DIST_W    = 32;
  // one lane term: a squared byte difference or a byte product fits 16 bits
  localparam int unsigned TERM_W    = 2 * BYTE_W;
  localparam int unsigned TREE_W    = TERM_W + $clog2(LANES);

  localparam logic [BYTE_W-1:0]    NIBBLE_MASK = 8'h0F;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX     = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SQ_BYTE   = 2'd0,
    MODE_DOT_BYTE  = 2'd1,
    MODE_SQ_NIBBLE = 2'd2
  } mode_e;

  typedef logic [LANES-1:0][TERM_W-1:0] term_vec_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/qvd_lane.sv @@
// quantized vector distance: one lane, byte pair to registered distance term
// depends on qvd_pkg
`default_nettype none

module qvd_lane
  import qvd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              adv_i,
  input  wire mode_e             mode_i,
  input  wire logic              lane_en_i,
  input  wire logic [BYTE_W-1:0] a_i,
  input  wire logic [BYTE_W-1:0] b_i,
  output logic [TERM_W-1:0]      term_o
);

  logic [BYTE_W-1:0] byte_diff;
  logic [NIB_W-1:0]  lo_a, lo_b, hi_a, hi_b, lo_diff, hi_diff;
  logic [BYTE_W-1:0] lo_sq, hi_sq;
  logic [BYTE_W-1:0] mul_a, mul_b;
  logic [TERM_W-1:0] mul_p;
  logic [TERM_W-1:0] term_d, term_q;

  always_comb begin
    byte_diff = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
    lo_a      = NIB_W'(a_i & NIBBLE_MASK);
    lo_b      = NIB_W'(b_i & NIBBLE_MASK);
    hi_a      = NIB_W'((a_i >> NIB_W) & NIBBLE_MASK);
    hi_b      = NIB_W'((b_i >> NIB_W) & NIBBLE_MASK);
    lo_diff   = (lo_a >= lo_b) ? (lo_a - lo_b) : (lo_b - lo_a);
    hi_diff   = (hi_a >= hi_b) ? (hi_a - hi_b) : (hi_b - hi_a);
    lo_sq     = BYTE_W'(lo_diff) * BYTE_W'(lo_diff);
    hi_sq     = BYTE_W'(hi_diff) * BYTE_W'(hi_diff);

    // the byte multiplier serves both the squared difference and the product
    if (mode_i == MODE_DOT_BYTE) begin
      mul_a = a_i;
      mul_b = b_i;
    end else begin
      mul_a = byte_diff;
      mul_b = byte_diff;
    end
    mul_p = TERM_W'(mul_a) * TERM_W'(mul_b);

    term_d = '0;
    if (lane_en_i) begin
      unique case (mode_i)
        MODE_SQ_BYTE:   term_d = mul_p;
        MODE_DOT_BYTE:  term_d = mul_p;
        MODE_SQ_NIBBLE: term_d = TERM_W'(lo_sq) + TERM_W'(hi_sq);
        default:        term_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

@@ hw/rtl/qvd_merge.sv @@
// quantized vector distance: lane adder tree, saturating accumulator, result register
// depends on qvd_pkg
`default_nettype none

module qvd_merge
  import qvd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire term_vec_t         terms_i,
  input  wire ctl_t              s1_ctl_i,
  input  wire logic              out_ready_i,
  output logic                   adv_o,
  output ctl_t                   s2_ctl_o,
  output logic                   out_valid_o,
  output logic [DIST_W-1:0]      distance_o,
  output logic                   saturated_o
);

  logic [TREE_W-1:0]    tree_d, tree_q;
  ctl_t                 s2_ctl_q;
  logic [SUM_WIDTH-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic [SUM_WIDTH:0]   sum_ext;
  logic                 out_valid_q;
  logic [DIST_W-1:0]    dist_q;
  logic                 sat_q;
  logic                 emit;

  always_comb begin
    tree_d = '0;
    for (int unsigned l = 0; l < LANES; l++) begin
      tree_d = tree_d + TREE_W'(terms_i[l]);
    end
  end

  // carry out of the wide add means the sum passed the top value
  always_comb begin
    sum_ext = {1'b0, acc_q} + (SUM_WIDTH + 1)'(tree_q);
    if (sum_ext[SUM_WIDTH]) begin
      acc_d = SUM_MAX;
      ovf_d = 1'b1;
    end else begin
      acc_d = sum_ext[SUM_WIDTH-1:0];
      ovf_d = ovf_q;
    end
  end

  // only a final transaction needs the result register free
  assign adv_o = !(out_valid_q && !out_ready_i && s2_ctl_q.valid && s2_ctl_q.last);
  assign emit  = adv_o && s2_ctl_q.valid && s2_ctl_q.last;

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      tree_q <= tree_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q    <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (adv_o) begin
        s2_ctl_q <= s1_ctl_i;
        if (s2_ctl_q.valid) begin
          if (s2_ctl_q.last) begin
            acc_q <= '0;
            ovf_q <= 1'b0;
          end else begin
            acc_q <= acc_d;
            ovf_q <= ovf_d;
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        dist_q      <= DIST_W'(acc_d);
        sat_q       <= ovf_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s2_ctl_o    = s2_ctl_q;
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

@@ hw/rtl/quantized_vector_distance.sv @@
// quantized vector distance: top level, lane array feeding the merge stage
// depends on qvd_pkg, qvd_lane, qvd_merge
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  input    | in_valid_i/in_ready_o  | first_bytes_i second_bytes_i valid_bytes_i last_chunk_i
//  output   | out_valid_o/out_ready_i| distance_o saturated_o
//  config   | cfg_we_i               | cfg_wdata_i (distance mode)
//
// one transaction per cycle while in_ready_o is high; a final chunk reaches the result through
// the lane multiply register, the adder tree register, then the accumulator and result register
// reset clears the mode to squared byte distance, the running sum and the flag
// input stalls only while a final chunk sits before the accumulator and the
// previous result has not been taken; other chunks keep accumulating meanwhile
`default_nettype none

module quantized_vector_distance
  import qvd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MODE_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DATA_W-1:0]  first_bytes_i,
  input  wire logic [DATA_W-1:0]  second_bytes_i,
  input  wire logic [COUNT_W-1:0] valid_bytes_i,
  input  wire logic               last_chunk_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [DIST_W-1:0]       distance_o,
  output logic                    saturated_o
);

  mode_e     mode_q;
  ctl_t      s1_ctl_q;
  ctl_t      s2_ctl;
  term_vec_t terms;
  logic      adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SQ_BYTE;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (adv) begin
      s1_ctl_q.valid <= in_valid_i;
      s1_ctl_q.last  <= last_chunk_i;
    end
  end

  assign in_ready_o = adv;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic lane_en;
    // counts above the lane count enable every lane
    assign lane_en = (valid_bytes_i > COUNT_W'(l));

    qvd_lane u_lane (
      .clk_i     (clk_i),
      .adv_i     (adv),
      .mode_i    (mode_q),
      .lane_en_i (lane_en),
      .a_i       (first_bytes_i[l*BYTE_W +: BYTE_W]),
      .b_i       (second_bytes_i[l*BYTE_W +: BYTE_W]),
      .term_o    (terms[l])
    );
  end

  qvd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .terms_i     (terms),
    .s1_ctl_i    (s1_ctl_q),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .s2_ctl_o    (s2_ctl),
    .out_valid_o (out_valid_o),
    .distance_o  (distance_o),
    .saturated_o (saturated_o)
  );

  a_stall_only_on_blocked_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && s2_ctl.valid && s2_ctl.last)
  ) else $error("input stalled without a blocked result");

  a_result_from_final_chunk: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s2_ctl.valid && s2_ctl.last)
  ) else $error("result not caused by a final chunk");

  a_saturated_is_clamped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (distance_o == DIST_W'(SUM_MAX))
  ) else $error("saturated result is not the top value");

endmodule

`default_nettype wire

@@ tb/quantized_vector_distance_tb.sv @@
// self-checking testbench for quantized_vector_distance: random bursts in, random stalls out
// depends on qvd_pkg and the quantized_vector_distance rtl; nothing else is read
`timescale 1ns / 1ps

module quantized_vector_distance_tb;
  import qvd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;  // valid lanes add nothing
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 400;

  typedef struct {
    logic [DATA_W-1:0]  first;
    logic [DATA_W-1:0]  second;
    logic [COUNT_W-1:0] count;
    logic               last;
  } chunk_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } distance_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [MODE_W-1:0]  cfg_wdata_i    = MODE_SQ_BYTE;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [DATA_W-1:0]  first_bytes_i  = '0;
  logic [DATA_W-1:0]  second_bytes_i = '0;
  logic [COUNT_W-1:0] valid_bytes_i  = '0;
  logic               last_chunk_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [DIST_W-1:0]  distance_o;
  logic               saturated_o;

  chunk_t    pending_chunks[$];
  distance_t expected_distances[$];

  // predictor state
  logic [MODE_W-1:0] mode_now = MODE_SQ_BYTE;
  logic [63:0]       running_total = '0;
  logic              clamp_seen = 1'b0;

  int unsigned mismatches = 0;
  bit          dense_send = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] rx_pattern = '1;
  int unsigned rx_slot = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  quantized_vector_distance dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_bytes_i  (first_bytes_i),
    .second_bytes_i (second_bytes_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_chunk_i   (last_chunk_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .distance_o     (distance_o),
    .saturated_o    (saturated_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] squared_gap(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? a - b : b - a;
    return 32'(d) * 32'(d);
  endfunction

  function automatic logic [31:0] chunk_weight(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] x,
                                               logic [DATA_W-1:0] y, logic [COUNT_W-1:0] count);
    int unsigned lanes;
    logic [31:0] acc;
    logic [7:0]  a;
    logic [7:0]  b;
    lanes = (count > LANES) ? LANES : count;
    acc = '0;
    for (int i = 0; i < lanes; i++) begin
      a = x[i*BYTE_W +: BYTE_W];
      b = y[i*BYTE_W +: BYTE_W];
      case (mode)
        MODE_SQ_BYTE: begin
          acc += squared_gap(a, b);
        end
        MODE_DOT_BYTE: begin
          acc += 32'(a) * 32'(b);
        end
        MODE_SQ_NIBBLE: begin
          acc += squared_gap(8'(a & NIBBLE_MASK), 8'(b & NIBBLE_MASK));
          acc += squared_gap(8'(a >> NIB_W), 8'(b >> NIB_W));
        end
        default: begin
        end
      endcase
    end
    return acc;
  endfunction

  // fold one accepted chunk into the running sum, queue the total on a final chunk
  task automatic accumulate_chunk(chunk_t c);
    logic [63:0] add;
    distance_t   d;
    add = 64'(chunk_weight(mode_now, c.first, c.second, c.count));
    if (add > 64'(SUM_MAX) - running_total) begin
      running_total = 64'(SUM_MAX);
      clamp_seen = 1'b1;
    end else begin
      running_total += add;
    end
    if (c.last) begin
      d.distance = running_total[DIST_W-1:0];
      d.saturated = clamp_seen;
      expected_distances.push_back(d);
      running_total = '0;
      clamp_seen = 1'b0;
    end
  endtask

  // driver: bursts of transactions with random gaps unless dense_send is set
  always @(posedge clk_i) begin
    chunk_t c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        c.first = first_bytes_i;
        c.second = second_bytes_i;
        c.count = valid_bytes_i;
        c.last = last_chunk_i;
        accumulate_chunk(c);
      end
      if (!in_valid_i || in_ready_o) begin
        if (!dense_send && gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_chunks.size() != 0) begin
          c = pending_chunks.pop_front();
          first_bytes_i <= c.first;
          second_bytes_i <= c.second;
          valid_bytes_i <= c.count;
          last_chunk_i <= c.last;
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold when one is requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rx_pattern[rx_slot];
        rx_slot = (rx_slot + 1) % 16;
      end
    end
  end

  // monitor: every result transaction is checked against the oldest expectation
  always @(posedge clk_i) begin
    distance_t d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d saturated %0b", distance_o, saturated_o);
      end else begin
        d = expected_distances.pop_front();
        if (distance_o !== d.distance || saturated_o !== d.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected distance %0d saturated %0b, got %0d %0b",
                     d.distance, d.saturated, distance_o, saturated_o);
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] random_bytes();
    return {$urandom, $urandom};
  endfunction

  task automatic push_chunk(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [COUNT_W-1:0] count, logic last);
    chunk_t c;
    c.first = x;
    c.second = y;
    c.count = count;
    c.last = last;
    pending_chunks.push_back(c);
  endtask

  // one vector pair with random content; an open vector carries into the next phase
  task automatic push_random_vector(int unsigned max_len, bit leave_open);
    int unsigned len;
    int unsigned pick;
    logic [DATA_W-1:0]  x;
    logic [DATA_W-1:0]  y;
    logic [COUNT_W-1:0] count;
    len = $urandom_range(1, max_len);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        count = '0;
      else if (pick == 1)
        count = COUNT_W'($urandom_range(LANES + 1, 15));
      else
        count = COUNT_W'($urandom_range(1, LANES));
      x = random_bytes();
      pick = $urandom_range(0, 9);
      case (pick)
        0: y = x;
        1: y = ~x;
        2: begin
          x = '1;
          y = '0;
        end
        3: begin
          // odd nibble count: zero padding nibble in both vectors
          y = random_bytes();
          if (count >= 1 && count <= LANES) begin
            x[count*BYTE_W-NIB_W +: NIB_W] = '0;
            y[count*BYTE_W-NIB_W +: NIB_W] = '0;
          end
        end
        default: y = random_bytes();
      endcase
      push_chunk(x, y, count, (k == len - 1) && !leave_open);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_chunks.size() != 0 || in_valid_i || expected_distances.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_mode(logic [MODE_W-1:0] m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_now = m;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned target;
    logic [MODE_W-1:0] m;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset mode is squared byte distance
    push_chunk('1, '0, 4'd8, 1'b1);
    push_chunk('0, '1, 4'd8, 1'b1);
    push_chunk(random_bytes(), random_bytes(), 4'd0, 1'b1);
    push_chunk(random_bytes(), random_bytes(), 4'd15, 1'b1);
    push_chunk(64'hFFFF_FFFF_FF12_3456, 64'h0000_0000_0065_4321, 4'd3, 1'b1);
    push_chunk(random_bytes(), random_bytes(), 4'd8, 1'b0);
    wait_idle();
    // mode change inside a vector
    set_mode(MODE_DOT_BYTE);
    push_chunk('1, '1, 4'd8, 1'b1);
    push_chunk('1, '1, 4'd9, 1'b1);
    push_chunk('1, '0, 4'd8, 1'b1);
    push_chunk(random_bytes(), random_bytes(), 4'd1, 1'b1);
    wait_idle();
    set_mode(MODE_SQ_NIBBLE);
    push_chunk(64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 1'b1);
    push_chunk(64'hAB_0C_DE, 64'hFF_05_71, 4'd3, 1'b0);
    push_chunk(random_bytes(), random_bytes(), 4'd12, 1'b1);
    wait_idle();
    set_mode(MODE_UNUSED);
    push_chunk('1, '0, 4'd8, 1'b0);
    push_chunk(random_bytes(), random_bytes(), 4'd8, 1'b1);
    push_chunk(random_bytes(), random_bytes(), 4'd0, 1'b1);
    wait_idle();

    // random phases, each with its own mode, sender style and receiver pattern
    for (int p = 0; p < 8; p++) begin
      m = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
      set_mode(m);
      dense_send = (p % 3 == 0);
      case ($urandom_range(0, 3))
        0: rx_pattern = '1;
        1: rx_pattern = 16'h5555;
        default: rx_pattern = 16'($urandom) | 16'h0001;
      endcase
      target = pending_chunks.size() + 180;
      if (p == 2) begin
        // long receiver hold with short vectors so the block backs up
        dense_send = 1'b1;
        hold_requests++;
        while (pending_chunks.size() < target)
          push_random_vector(2, 1'b0);
      end else begin
        while (pending_chunks.size() < target)
          push_random_vector(12, 1'b0);
        if (p != 7 && $urandom_range(0, 2) == 0)
          push_random_vector(3, 1'b1);
      end
      wait_idle();
    end
    set_mode(MODE_SQ_BYTE);

    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/qvd_pkg.sv
hw/rtl/qvd_lane.sv
hw/rtl/qvd_merge.sv
hw/rtl/quantized_vector_distance.sv
tb/quantized_vector_distance_tb.sv
